// File: src/tgss_pkg.sv
// Shared types and constants for the triangle gradient span shader.
package tgss_pkg;

    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 64;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_MAP_ROW_U     = 3'd0,
        REG_MAP_ROW_V     = 3'd1,
        REG_BASE_COLOR    = 3'd2,
        REG_DELTA_COLOR_U = 3'd3,
        REG_DELTA_COLOR_V = 3'd4
    } cfg_index_t;

    localparam int UvWidth = 40;
    localparam int ChWidth = 60;
    localparam int Ch16Width = 17;
    localparam logic [ChWidth-1:0] ChOne = ChWidth'(64'd1 << 33);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SETUP,
        BK_RUN
    } back_state_t;

endpackage

// File: src/triangle_gradient_span_shader.sv
// Span shader: u and v are set up, then the span's pixels pass the shading pipeline. The
// back end issues one pixel per cycle while out_ready does not stall the output; a pixel
// passes s1, s2, s3 and the output register. Setup of u and v at the span start sets the
// gap between spans. Reset zeroes all config registers and empties the request queue.
module triangle_gradient_span_shader
    import tgss_pkg::*;
#(
    parameter int MAX_SPAN = 64,
    parameter int COORD_WIDTH = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] start_x,
    input  logic [COORD_WIDTH-1:0] row_y,
    input  logic [6:0]             span_count,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            pixel,
    output logic                   last_pixel
);

    localparam int CNT_WIDTH = $clog2(MAX_SPAN + 1);

    logic [63:0] map_u_reg, map_v_reg, base_reg, du_reg, dv_reg;
    logic q_valid, q_ready;
    logic [COORD_WIDTH-1:0] q_x, q_y;
    logic [CNT_WIDTH-1:0] q_n;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_u_reg <= '0;
            map_v_reg <= '0;
            base_reg <= '0;
            du_reg <= '0;
            dv_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAP_ROW_U:     map_u_reg <= cfg_data;
                REG_MAP_ROW_V:     map_v_reg <= cfg_data;
                REG_BASE_COLOR:    base_reg <= cfg_data;
                REG_DELTA_COLOR_U: du_reg <= cfg_data;
                REG_DELTA_COLOR_V: dv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tgss_front #(
        .MAX_SPAN(MAX_SPAN),
        .COORD_WIDTH(COORD_WIDTH),
        .CNT_WIDTH(CNT_WIDTH)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_x(start_x), .row_y(row_y), .span_count(span_count),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_x(q_x), .q_y(q_y), .q_n(q_n)
    );

    tgss_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .CNT_WIDTH(CNT_WIDTH)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_x(q_x), .q_y(q_y), .q_n(q_n),
        .map_u(map_u_reg), .map_v(map_v_reg), .base_c(base_reg),
        .dcol_u(du_reg), .dcol_v(dv_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .pixel(pixel), .last_pixel(last_pixel)
    );

endmodule

// File: src/tgss_front.sv
// Front end: clamps the span count to MAX_SPAN and queues nonzero requests for the back end.
module tgss_front
    import tgss_pkg::*;
#(
    parameter int MAX_SPAN = 64,
    parameter int COORD_WIDTH = 12,
    parameter int CNT_WIDTH = 7
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] start_x,
    input  logic [COORD_WIDTH-1:0] row_y,
    input  logic [6:0]             span_count,
    output logic                   q_valid,
    input  logic                   q_ready,
    output logic [COORD_WIDTH-1:0] q_x,
    output logic [COORD_WIDTH-1:0] q_y,
    output logic [CNT_WIDTH-1:0]   q_n
);

    localparam int QW = 2 * COORD_WIDTH + CNT_WIDTH;

    logic [QW-1:0] mem_reg [2];
    logic [1:0]    wp_reg, rp_reg;
    logic [CNT_WIDTH-1:0] n_sat;
    logic push, pop;

    always_comb
    begin
        if (32'(span_count) > 32'(MAX_SPAN))
            n_sat = CNT_WIDTH'(MAX_SPAN);
        else
            n_sat = CNT_WIDTH'(span_count);
    end

    assign in_ready = (wp_reg - rp_reg) != 2'd2;
    assign q_valid = wp_reg != rp_reg;
    assign push = in_valid && in_ready && (span_count != 7'd0);
    assign pop = q_valid && q_ready;
    assign {q_x, q_y, q_n} = mem_reg[rp_reg[0]];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg[0]] <= {start_x, row_y, n_sat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
        end
    end

endmodule

// File: src/tgss_back.sv
// Back end: steps u and v along the span and shades one pixel per cycle while the output is not stalled.
module tgss_back
    import tgss_pkg::*;
#(
    parameter int COORD_WIDTH = 12,
    parameter int CNT_WIDTH = 7
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [COORD_WIDTH-1:0] q_x,
    input  logic [COORD_WIDTH-1:0] q_y,
    input  logic [CNT_WIDTH-1:0]   q_n,
    input  logic [63:0]            map_u,
    input  logic [63:0]            map_v,
    input  logic [63:0]            base_c,
    input  logic [63:0]            dcol_u,
    input  logic [63:0]            dcol_v,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            pixel,
    output logic                   last_pixel
);

    back_state_t state_reg, state_next;
    logic [COORD_WIDTH-1:0] x_reg, y_reg;
    logic [CNT_WIDTH-1:0]   n_reg;
    logic signed [UvWidth-1:0] u_reg, v_reg, u_next, v_next;
    logic signed [UvWidth-1:0] uterm_reg, vterm_reg;
    logic [1:0] ph_reg;

    // Shading pipeline: s1 channels, s2 clamp, s3 premultiply, o output.
    logic s1_v_reg, s2_v_reg, s3_v_reg, o_v_reg;
    logic s1_l_reg, s2_l_reg, s3_l_reg, o_l_reg;
    logic signed [ChWidth-1:0] ch_reg [4];
    logic [Ch16Width-1:0] c16_reg [4];
    logic [7:0] a8_reg;
    logic [41:0] pm_reg [3];
    logic [31:0] pix_reg;
    logic adv, issue;

    assign adv = !o_v_reg || out_ready;
    assign issue = (state_reg == BK_RUN) && adv;
    assign q_ready = (state_reg == BK_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (q_valid) state_next = BK_SETUP;
            BK_SETUP: if (ph_reg == 2'd2) state_next = BK_RUN;
            BK_RUN:   if (issue && n_reg == CNT_WIDTH'(1)) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Setup computes and registers the x terms, then the y terms together with the sum.
    function automatic logic signed [UvWidth-1:0] term(
        input logic [19:0] coef, input logic [COORD_WIDTH-1:0] p);
        logic signed [COORD_WIDTH+1:0] q;
        begin
            q = $signed({1'b0, p, 1'b1});
            term = UvWidth'($signed(coef)) * UvWidth'(q);
        end
    endfunction

    always_comb
    begin
        u_next = u_reg;
        v_next = v_reg;
        if (ph_reg == 2'd2)
        begin
            u_next = uterm_reg + term(map_u[39:20], y_reg)
                + UvWidth'($signed({map_u[63:40], 3'b000}));
            v_next = vterm_reg + term(map_v[39:20], y_reg)
                + UvWidth'($signed({map_v[63:40], 3'b000}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && q_valid)
        begin
            x_reg <= q_x;
            y_reg <= q_y;
        end
        if (state_reg == BK_SETUP)
        begin
            if (ph_reg == 2'd1)
            begin
                uterm_reg <= term(map_u[19:0], x_reg);
                vterm_reg <= term(map_v[19:0], x_reg);
            end
            u_reg <= u_next;
            v_reg <= v_next;
        end
        else if (issue)
        begin
            u_reg <= u_reg + UvWidth'($signed({map_u[19:0], 1'b0}));
            v_reg <= v_reg + UvWidth'($signed({map_v[19:0], 1'b0}));
        end
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ch_reg[k] <= ChWidth'($signed({base_c[16*k +: 16], 19'd0}))
                    + ChWidth'(u_reg) * ChWidth'($signed(dcol_u[16*k +: 16]))
                    + ChWidth'(v_reg) * ChWidth'($signed(dcol_v[16*k +: 16]));
                if (ch_reg[k] < 0)
                    c16_reg[k] <= '0;
                else if (ch_reg[k] > $signed(ChOne))
                    c16_reg[k] <= Ch16Width'(65536);
                else
                    c16_reg[k] <= ch_reg[k][33:17];
            end
            a8_reg <= 8'((25'(c16_reg[3]) * 25'd255 + 25'd32768) >> 16);
            for (int k = 0; k < 3; k++)
                pm_reg[k] <= 42'(c16_reg[k]) * 42'(c16_reg[3]) * 42'd255;
            pix_reg <= {a8_reg,
                8'((pm_reg[2] + 42'(32'h8000_0000)) >> 32),
                8'((pm_reg[1] + 42'(32'h8000_0000)) >> 32),
                8'((pm_reg[0] + 42'(32'h8000_0000)) >> 32)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            n_reg <= '0;
            ph_reg <= '0;
            {s1_v_reg, s2_v_reg, s3_v_reg, o_v_reg} <= '0;
            {s1_l_reg, s2_l_reg, s3_l_reg, o_l_reg} <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_IDLE && q_valid)
            begin
                n_reg <= q_n;
                ph_reg <= 2'd1;
            end
            else if (state_reg == BK_SETUP)
                ph_reg <= ph_reg + 2'd1;
            else if (issue)
                n_reg <= n_reg - CNT_WIDTH'(1);
            if (adv)
            begin
                s1_v_reg <= issue;
                s1_l_reg <= issue && n_reg == CNT_WIDTH'(1);
                s2_v_reg <= s1_v_reg;
                s2_l_reg <= s1_l_reg;
                s3_v_reg <= s2_v_reg;
                s3_l_reg <= s2_l_reg;
                o_v_reg <= s3_v_reg;
                o_l_reg <= s3_l_reg;
            end
        end
    end

    assign out_valid = o_v_reg;
    assign pixel = pix_reg;
    assign last_pixel = o_l_reg;

endmodule
